@@ rtl/aehp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aehp_pkg
// Shared types and constants for the archive entry header parser.
// ----------------------------------------------------------------------------
package aehp_pkg;

	// Byte index width: holds 28 + two 16-bit name lengths
	localparam int IDX_W     = 18;
	localparam int FIXED_LEN = 28;
	localparam int SUM_FIRST = 4;
	// bit position of the directory flag in the attribute byte
	localparam int DIR_BIT   = 4;

	localparam logic [31:0] TAG_GZIP = 32'h5049_5A47;
	localparam logic [31:0] TAG_BZ2  = 32'h0032_5A42;

	localparam logic [1:0] METHOD_GZIP  = 2'd0;
	localparam logic [1:0] METHOD_BZ2   = 2'd1;
	localparam logic [1:0] METHOD_OTHER = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_header;
	} byte_item_t;

	typedef struct packed {
		logic        checksum_ok;
		logic [1:0]  method_code;
		logic [31:0] packed_size;
		logic [31:0] unpacked_size;
		logic [15:0] dos_date;
		logic [15:0] dos_time;
		logic [7:0]  attributes;
		logic        is_directory;
		logic [15:0] store_mode;
		logic [15:0] dir_part_len;
		logic [15:0] file_part_len;
	} hdr_item_t;

	function automatic logic [1:0] method_of(input logic [31:0] tag);
		logic [1:0] code;
		code = METHOD_OTHER;
		if (tag == TAG_GZIP) begin
			code = METHOD_GZIP;
		end else if (tag == TAG_BZ2) begin
			code = METHOD_BZ2;
		end
		return code;
	endfunction

endpackage

@@ rtl/aehp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aehp_core
// Per-byte parse state: field capture, byte counter and checksum sum.
// ----------------------------------------------------------------------------
module aehp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  aehp_pkg::byte_item_t  item,
	output logic                  emit,
	output aehp_pkg::hdr_item_t   result
);

	localparam int OFS_TAG   = 4;
	localparam int OFS_PSIZE = 8;
	localparam int OFS_USIZE = 12;
	localparam int OFS_DATE  = 16;
	localparam int OFS_TIME  = 18;
	localparam int OFS_ATTR  = 20;
	localparam int OFS_MODE  = 22;
	localparam int OFS_DIR   = 24;
	localparam int OFS_FILE  = 26;

	logic                          active_q;
	logic [aehp_pkg::IDX_W-1:0]    idx_q;
	logic [31:0] sum_q, stored_q, tag_q, psize_q, usize_q;
	logic [15:0] date_q, time_q, mode_q, dir_q, file_q;
	logic [7:0]  attr_q;

	logic                          act;
	logic [aehp_pkg::IDX_W-1:0]    idx, idx_n, total;
	logic [1:0]                    lane;
	logic [7:0]                    b;
	logic [31:0] sum_n, stored_n, tag_n, psize_n, usize_n;
	logic [15:0] date_n, time_n, mode_n, dir_n, file_n;
	logic [7:0]  attr_n;
	logic        done;

	always_comb begin
		b    = item.data_byte;
		act  = item.start_header | active_q;
		idx  = item.start_header ? '0 : idx_q;
		lane = idx[1:0];

		// start clears all captured fields
		sum_n    = item.start_header ? '0 : sum_q;
		stored_n = item.start_header ? '0 : stored_q;
		tag_n    = item.start_header ? '0 : tag_q;
		psize_n  = item.start_header ? '0 : psize_q;
		usize_n  = item.start_header ? '0 : usize_q;
		date_n   = item.start_header ? '0 : date_q;
		time_n   = item.start_header ? '0 : time_q;
		attr_n   = item.start_header ? '0 : attr_q;
		mode_n   = item.start_header ? '0 : mode_q;
		dir_n    = item.start_header ? '0 : dir_q;
		file_n   = item.start_header ? '0 : file_q;

		if (idx < aehp_pkg::IDX_W'(aehp_pkg::SUM_FIRST)) begin
			stored_n[{lane, 3'b000} +: 8] = b;
		end else begin
			sum_n = sum_n + {{24{b[7]}}, b};
		end

		if (idx < aehp_pkg::IDX_W'(OFS_TAG)) begin
			// checksum bytes handled above
		end else if (idx < aehp_pkg::IDX_W'(OFS_PSIZE)) begin
			tag_n[{lane, 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_USIZE)) begin
			psize_n[{lane, 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_DATE)) begin
			usize_n[{lane, 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_TIME)) begin
			date_n[{lane[0], 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_ATTR)) begin
			time_n[{lane[0], 3'b000} +: 8] = b;
		end else if (idx == aehp_pkg::IDX_W'(OFS_ATTR)) begin
			attr_n = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_MODE)) begin
			// header type byte: summed, not kept
		end else if (idx < aehp_pkg::IDX_W'(OFS_DIR)) begin
			mode_n[{lane[0], 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(OFS_FILE)) begin
			dir_n[{lane[0], 3'b000} +: 8] = b;
		end else if (idx < aehp_pkg::IDX_W'(aehp_pkg::FIXED_LEN)) begin
			file_n[{lane[0], 3'b000} +: 8] = b;
		end

		idx_n = idx + 1'b1;
		total = aehp_pkg::IDX_W'(aehp_pkg::FIXED_LEN)
		      + aehp_pkg::IDX_W'(dir_n) + aehp_pkg::IDX_W'(file_n);
		// total is never below the fixed length, so equality alone suffices
		done  = (idx_n == total);
		emit  = step & act & done;

		result.checksum_ok   = (sum_n == stored_n);
		result.method_code   = aehp_pkg::method_of(tag_n);
		result.packed_size   = psize_n;
		result.unpacked_size = usize_n;
		result.dos_date      = date_n;
		result.dos_time      = time_n;
		result.attributes    = attr_n;
		result.is_directory  = attr_n[aehp_pkg::DIR_BIT];
		result.store_mode    = mode_n;
		result.dir_part_len  = dir_n;
		result.file_part_len = file_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (step && act) begin
			active_q <= ~done;
			idx_q    <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && act) begin
			sum_q    <= sum_n;
			stored_q <= stored_n;
			tag_q    <= tag_n;
			psize_q  <= psize_n;
			usize_q  <= usize_n;
			date_q   <= date_n;
			time_q   <= time_n;
			attr_q   <= attr_n;
			mode_q   <= mode_n;
			dir_q    <= dir_n;
			file_q   <= file_n;
		end
	end

	// an idle byte never produces a header
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.start_header && !active_q) |-> !emit)
		else $error("aehp_core: result without active parse");

	// a finished header leaves the parser idle
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !active_q)
		else $error("aehp_core: parse still active after result");

	// the counter never runs past the end of the header
	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q < aehp_pkg::IDX_W'(aehp_pkg::FIXED_LEN)
		              || idx_q < aehp_pkg::IDX_W'(aehp_pkg::FIXED_LEN)
		                 + aehp_pkg::IDX_W'(dir_q) + aehp_pkg::IDX_W'(file_q)))
		else $error("aehp_core: byte index beyond header length");

endmodule

@@ rtl/archive_entry_header_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_entry_header_parser_top
// Byte-stream parser for one archive entry header per result item.
// ----------------------------------------------------------------------------
// Usage:
//  - byte channel (byte_valid/byte_ready/byte_item): one header byte per item.
//    start_header marks byte 0 and restarts any parse in progress. Bytes that
//    arrive with no parse active are dropped without a result.
//  - hdr channel (hdr_valid/hdr_ready/hdr_item): one item per header, after
//    the last name byte (after byte 27 when both name lengths are zero), with
//    the decoded fields, checksum verdict and method code.
//  - The result of a header's last byte reaches hdr_item through the input
//    register and then the result register after that byte is accepted.
//  - Throughput: one byte per cycle unless hdr_ready stalls; the parse step is
//    one pass: field capture, 32-bit add/compare, 18-bit length compare.
//  - Reset clears the parse state and both pipeline valids; no header is
//    active afterwards.
//  - If the receiver stalls with a result pending, the input register holds
//    one further byte and byte_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module archive_entry_header_parser_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  aehp_pkg::byte_item_t  byte_item,
	output logic                  hdr_valid,
	input  logic                  hdr_ready,
	output aehp_pkg::hdr_item_t   hdr_item
);

	// input register
	logic                 valid_s1;
	aehp_pkg::byte_item_t item_s1;

	// result register
	logic                 hdr_valid_q;
	aehp_pkg::hdr_item_t  hdr_item_q;

	logic                 adv;
	logic                 step;
	logic                 emit;
	aehp_pkg::hdr_item_t  result;

	// stage 1 may move on whenever the result slot is free or being emptied
	assign adv        = ~hdr_valid_q | hdr_ready;
	assign step       = valid_s1 & adv;
	assign byte_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hdr_valid_q <= 1'b0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (adv) begin
				hdr_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
		if (emit) begin
			hdr_item_q <= result;
		end
	end

	aehp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	assign hdr_valid = hdr_valid_q;
	assign hdr_item  = hdr_item_q;

	// with no result pending the block always takes a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!hdr_valid_q |-> byte_ready)
		else $error("top: input stalled with empty result slot");

	// a stalled byte stays in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("top: stalled byte lost");

	// method code is one of the three defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid_q |-> (hdr_item_q.method_code == aehp_pkg::METHOD_GZIP
		                 || hdr_item_q.method_code == aehp_pkg::METHOD_BZ2
		                 || hdr_item_q.method_code == aehp_pkg::METHOD_OTHER))
		else $error("top: undefined method code");

	// directory flag follows the attribute byte
	assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid_q |-> (hdr_item_q.is_directory
		                 == hdr_item_q.attributes[aehp_pkg::DIR_BIT]))
		else $error("top: directory flag mismatch");

endmodule
